FILE: design/cst_pkg.sv
// Shared types and constants for the city state tracker.
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

    localparam int TIME_W   = 20;
    localparam int DIST_W   = 24;
    localparam int FTIME_W  = 10;
    localparam int FDIST_W  = 12;
    localparam int BRIGHT_W = 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // tracker modes
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_MAYBE    = 2'd1;
    localparam logic [1:0] MODE_WAIT     = 2'd2;
    localparam logic [1:0] MODE_DETECTED = 2'd3;

    // held decision
    localparam logic [1:0] OUT_NOT   = 2'd0;
    localparam logic [1:0] OUT_MAYBE = 2'd1;
    localparam logic [1:0] OUT_DTCD  = 2'd2;

    // report classes
    localparam logic [1:0] REPORT_NONE     = 2'd0;
    localparam logic [1:0] REPORT_MAYBE    = 2'd1;
    localparam logic [1:0] REPORT_DETECTED = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_BRIGHT_THR = 3'd0;
    localparam logic [2:0] REG_MAYBE_TIME = 3'd1;
    localparam logic [2:0] REG_MAYBE_DIST = 3'd2;
    localparam logic [2:0] REG_MAYBE_MAX  = 3'd3;
    localparam logic [2:0] REG_CITY_TIME  = 3'd4;
    localparam logic [2:0] REG_CITY_DIST  = 3'd5;

    // register reset values
    localparam logic [BRIGHT_W-1:0] RST_BRIGHT_THR = 3'd3;
    localparam logic [TIME_W-1:0]   RST_MAYBE_TIME = 20'd1000;
    localparam logic [DIST_W-1:0]   RST_MAYBE_DIST = 24'd5000;
    localparam logic [DIST_W-1:0]   RST_MAYBE_MAX  = 24'd20000;
    localparam logic [TIME_W-1:0]   RST_CITY_TIME  = 20'd6000;
    localparam logic [DIST_W-1:0]   RST_CITY_DIST  = 24'd10000;

    typedef struct packed {
        logic [TIME_W-1:0] maybe_min_time;
        logic [DIST_W-1:0] maybe_min_dist;
        logic [DIST_W-1:0] maybe_max_dist;
        logic [TIME_W-1:0] city_min_time;
        logic [DIST_W-1:0] city_min_dist;
    } cfg_t;

    // classified frame as it travels from front to back
    typedef struct packed {
        logic               rep_none;
        logic               rep_maybe;
        logic               rep_det;
        logic               bright;
        logic               may_leave;
        logic [FTIME_W-1:0] frame_time;
        logic [FDIST_W-1:0] frame_dist;
    } item_t;

endpackage
`default_nettype wire

FILE: design/city_state_tracker.sv
// City state tracker: one result per frame, passed through the queue and then the
// result register. Throughput is one frame per cycle unless the result side stalls;
// the queue between front end and state machine holds up to QUEUE_DEPTH frames
// while the result side is stalled. The state machine and accumulators update once
// per frame. Reset (rst_n low, async): mode idle, accumulators zero, decision not
// detected, registers at their defaults, queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none
module city_state_tracker
    import cst_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          city_report,
    input  wire logic [BRIGHT_W-1:0] brightness_level,
    input  wire logic                min_speed_off,
    input  wire logic [FTIME_W-1:0]  frame_time_ms,
    input  wire logic [FDIST_W-1:0]  frame_dist_cm,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               city_out,
    output logic [1:0]               tracker_state
);

    localparam int ITEM_W = $bits(item_t);

    logic [BRIGHT_W-1:0] bright_thr_reg;
    cfg_t                cfg_reg;
    logic                cfg_wr;
    logic [2:0]          reg_idx;

    logic                push_valid, push_ready;
    item_t               push_data;
    logic                q_valid, q_ready;
    item_t               q_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_thr_reg         <= RST_BRIGHT_THR;
            cfg_reg.maybe_min_time <= RST_MAYBE_TIME;
            cfg_reg.maybe_min_dist <= RST_MAYBE_DIST;
            cfg_reg.maybe_max_dist <= RST_MAYBE_MAX;
            cfg_reg.city_min_time  <= RST_CITY_TIME;
            cfg_reg.city_min_dist  <= RST_CITY_DIST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_BRIGHT_THR: bright_thr_reg         <= pwdata[BRIGHT_W-1:0];
                REG_MAYBE_TIME: cfg_reg.maybe_min_time <= pwdata[TIME_W-1:0];
                REG_MAYBE_DIST: cfg_reg.maybe_min_dist <= pwdata[DIST_W-1:0];
                REG_MAYBE_MAX:  cfg_reg.maybe_max_dist <= pwdata[DIST_W-1:0];
                REG_CITY_TIME:  cfg_reg.city_min_time  <= pwdata[TIME_W-1:0];
                REG_CITY_DIST:  cfg_reg.city_min_dist  <= pwdata[DIST_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BRIGHT_THR: prdata = DATA_W'(bright_thr_reg);
            REG_MAYBE_TIME: prdata = DATA_W'(cfg_reg.maybe_min_time);
            REG_MAYBE_DIST: prdata = DATA_W'(cfg_reg.maybe_min_dist);
            REG_MAYBE_MAX:  prdata = DATA_W'(cfg_reg.maybe_max_dist);
            REG_CITY_TIME:  prdata = DATA_W'(cfg_reg.city_min_time);
            REG_CITY_DIST:  prdata = DATA_W'(cfg_reg.city_min_dist);
            default:        prdata = '0;
        endcase
    end

    cst_front u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .city_report      (city_report),
        .brightness_level (brightness_level),
        .min_speed_off    (min_speed_off),
        .frame_time_ms    (frame_time_ms),
        .frame_dist_cm    (frame_dist_cm),
        .bright_threshold (bright_thr_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_data        (push_data)
    );

    cst_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    cst_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (q_valid),
        .pop_ready     (q_ready),
        .pop_data      (q_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .city_out      (city_out),
        .tracker_state (tracker_state)
    );

    // decision always follows from the mode it was emitted with
    a_out_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((tracker_state == MODE_IDLE     && city_out == OUT_NOT)   ||
             (tracker_state == MODE_WAIT     && city_out == OUT_NOT)   ||
             (tracker_state == MODE_MAYBE    && city_out == OUT_MAYBE) ||
             (tracker_state == MODE_DETECTED && city_out == OUT_DTCD)))
        else $error("city_out inconsistent with tracker_state");

    // an accepted frame is either still queued or already in the result register
    a_frame_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (q_valid || out_valid))
        else $error("accepted frame vanished");

    // back end takes a frame whenever the result side is free
    a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !out_valid) |=> out_valid)
        else $error("back end failed to take a queued frame");

endmodule
`default_nettype wire

FILE: design/cst_front.sv
// Front end: takes frames in and classifies report and brightness.
`timescale 1ns / 1ps
`default_nettype none
module cst_front
    import cst_pkg::*;
(
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          city_report,
    input  wire logic [BRIGHT_W-1:0] brightness_level,
    input  wire logic                min_speed_off,
    input  wire logic [FTIME_W-1:0]  frame_time_ms,
    input  wire logic [FDIST_W-1:0]  frame_dist_cm,
    input  wire logic [BRIGHT_W-1:0] bright_threshold,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output item_t                    push_data
);

    logic bright;

    assign bright     = brightness_level >= bright_threshold;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_data.rep_none   = city_report == REPORT_NONE;
        push_data.rep_maybe  = city_report == REPORT_MAYBE;
        push_data.rep_det    = city_report == REPORT_DETECTED;
        push_data.bright     = bright;
        push_data.may_leave  = bright || !min_speed_off;
        push_data.frame_time = frame_time_ms;
        push_data.frame_dist = frame_dist_cm;
    end

endmodule
`default_nettype wire

FILE: design/cst_queue.sv
// Short FIFO between the front end and the state machine.
`timescale 1ns / 1ps
`default_nettype none
module cst_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: design/cst_back.sv
// Back end: tracker state machine, saturating accumulators, held result.
`timescale 1ns / 1ps
`default_nettype none
module cst_back
    import cst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  wire item_t pop_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [1:0] city_out,
    output logic [1:0] tracker_state
);

    logic [1:0]        mode_reg, mode_next;
    logic [1:0]        held_reg, held_next;
    logic [TIME_W-1:0] time_reg, time_next, time_sat;
    logic [DIST_W-1:0] dist_reg, dist_next, dist_sat;
    logic [TIME_W:0]   time_sum;
    logic [DIST_W:0]   dist_sum;
    logic              out_valid_reg, out_valid_next;
    logic              pop;

    // result register frees up when empty or being taken
    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;

    assign time_sum = {1'b0, time_reg} + (TIME_W + 1)'(pop_data.frame_time);
    assign dist_sum = {1'b0, dist_reg} + (DIST_W + 1)'(pop_data.frame_dist);
    assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
    assign dist_sat = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        time_next = time_reg;
        dist_next = dist_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                time_next = '0;
                dist_next = '0;
                if (pop_data.rep_det && pop_data.bright)
                begin
                    mode_next = MODE_DETECTED;
                    held_next = OUT_DTCD;
                end
                else if (pop_data.rep_maybe && pop_data.bright)
                begin
                    mode_next = MODE_MAYBE;
                    held_next = OUT_MAYBE;
                end
            end
            MODE_MAYBE:
            begin
                // tests here use the totals including this frame
                time_next = time_sat;
                dist_next = dist_sat;
                if (pop_data.rep_det && pop_data.bright)
                begin
                    mode_next = MODE_DETECTED;
                    held_next = OUT_DTCD;
                    time_next = '0;
                    dist_next = '0;
                end
                else if (pop_data.rep_maybe)
                begin
                    if (dist_sat > cfg.maybe_max_dist)
                    begin
                        mode_next = MODE_WAIT;
                        held_next = OUT_NOT;
                    end
                end
                else if (pop_data.rep_none && time_sat > cfg.maybe_min_time &&
                         dist_sat > cfg.maybe_min_dist && pop_data.may_leave)
                begin
                    mode_next = MODE_IDLE;
                    held_next = OUT_NOT;
                end
            end
            MODE_WAIT:
            begin
                if (pop_data.rep_none || pop_data.rep_det)
                begin
                    mode_next = MODE_IDLE;
                    held_next = OUT_NOT;
                end
            end
            default:
            begin
                // detected: test on old totals, then add this frame
                time_next = time_sat;
                dist_next = dist_sat;
                if (pop_data.rep_none && time_reg > cfg.city_min_time &&
                    dist_reg > cfg.city_min_dist && pop_data.may_leave)
                begin
                    mode_next = MODE_IDLE;
                    held_next = OUT_NOT;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            held_reg      <= OUT_NOT;
            time_reg      <= '0;
            dist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                time_reg <= time_next;
                dist_reg <= dist_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign city_out      = held_reg;
    assign tracker_state = mode_reg;

endmodule
`default_nettype wire
